>>> hw/rtl/fdbh_pkg.sv
package fdbh_pkg;

  // hash constants
  localparam logic [31:0] FnvBasis  = 32'd2166136261;
  localparam logic [31:0] FnvPrime  = 32'd16777619;
  localparam logic [7:0]  StringMul = 8'hff;

  // queue between front and back
  localparam int unsigned QueueDepthDefault = 2;

  // register map
  localparam int unsigned AddrW          = 3;
  localparam logic [AddrW-1:0] AddrStringMode = 3'd0;

  // one classified beat as it travels from front to back
  typedef struct packed {
    logic [15:0] operand;
    logic        has_byte;
    logic        last;
  } item_t;

  // back engine status toward the top level
  typedef struct packed {
    logic finalizing;
    logic pop;
  } bk_status_t;

  // one fnv-1a step: xor, then multiply by the prime mod 2^32
  // prime = 2^24 + 403, and 403 = 256 + 128 + 16 + 2 + 1
  function automatic logic [31:0] fdbh_absorb(logic [31:0] h, logic [15:0] op);
    logic [31:0] x;
    x = h ^ {16'd0, op};
    return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

>>> hw/rtl/fdbh_queue.sv
module fdbh_queue
  import fdbh_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/fdbh_front.sv
module fdbh_front
  import fdbh_pkg::*;
(
  input  logic       item_valid_i,
  output logic       item_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       last_i,
  input  logic       string_mode_i,
  input  logic       queue_full_i,
  output logic       push_o,
  output item_t      push_item_o
);

  logic [15:0] scaled;

  // byte times 255 is (byte << 8) - byte
  assign scaled = {data_byte_i, 8'd0} - {8'd0, data_byte_i};

  // classify the beat and hand it to the queue
  assign item_stall_o          = queue_full_i;
  assign push_o                = item_valid_i && !queue_full_i;
  assign push_item_o.operand   = string_mode_i ? scaled : {8'd0, data_byte_i};
  assign push_item_o.has_byte  = has_byte_i;
  assign push_item_o.last      = last_i;

endmodule

>>> hw/rtl/fdbh_back.sv
module fdbh_back
  import fdbh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        hash_valid_o,
  input  logic        hash_stall_i,
  output logic [31:0] hash_value_o,
  output bk_status_t  status_o
);

  typedef enum logic {
    StAbsorb,
    StFinal
  } state_e;

  state_e      state_q;
  logic [31:0] hash_q, first_q, fin_q, out_hash_q;
  logic [1:0]  cnt_q;
  logic        out_valid_q;
  logic        out_free;
  logic        out_load;
  logic [31:0] abs_hash, fin_step;
  logic [7:0]  fin_byte;

  assign out_free = !out_valid_q || !hash_stall_i;
  assign out_load = (state_q == StFinal) && (cnt_q == 2'd3) && out_free;
  assign q_pop_o  = (state_q == StAbsorb) && q_valid_i;

  // first pass step on the queued beat
  assign abs_hash = q_item_i.has_byte ? fdbh_absorb(hash_q, q_item_i.operand) : hash_q;

  // second pass step, least significant byte first
  assign fin_byte = 8'(first_q >> {cnt_q, 3'b000});
  assign fin_step = fdbh_absorb(fin_q, {8'd0, fin_byte});

  assign hash_valid_o        = out_valid_q;
  assign hash_value_o        = out_hash_q;
  assign status_o.finalizing = (state_q == StFinal);
  assign status_o.pop        = q_pop_o;

  // sequencer, running value and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StAbsorb;
      hash_q      <= FnvBasis;
      first_q     <= '0;
      fin_q       <= FnvBasis;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_hash_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!hash_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StAbsorb: begin
          if (q_valid_i) begin
            if (q_item_i.last) begin
              first_q <= abs_hash;
              hash_q  <= FnvBasis;
              fin_q   <= FnvBasis;
              cnt_q   <= '0;
              state_q <= StFinal;
            end else begin
              hash_q <= abs_hash;
            end
          end
        end
        StFinal: begin
          if (cnt_q != 2'd3) begin
            fin_q <= fin_step;
            cnt_q <= cnt_q + 1'b1;
          end else if (out_free) begin
            out_hash_q  <= fin_step;
            state_q     <= StAbsorb;
          end
        end
        default: begin
          state_q <= StAbsorb;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/fnv1a_double_byte_hash.sv
// Double-pass FNV-1a 32-bit hash. Message bytes arrive one beat at a time and
// are folded into a 32-bit running value that starts at the offset basis; with
// string_mode set each byte is scaled by 255 first. A beat may carry no byte,
// and the beat marked last closes the message: its byte (if any) is absorbed,
// the four bytes of the running value are hashed again with plain FNV-1a, the
// result appears on hash_value_o and the running value returns to the basis.
// Throughput is one beat per cycle while the back engine absorbs; after a last
// beat it runs the second pass, one byte a cycle, the last byte once the result
// register is free. A queue of QueueDepth beats between the input side and the
// engine takes input beats until it fills while the engine finishes a message
// or waits on a stalled result. string_mode is sampled as each beat enters.
module fnv1a_double_byte_hash
  import fdbh_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input beats
  input  logic             item_valid_i,
  output logic             item_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             has_byte_i,
  input  logic             last_i,
  // result beats
  output logic             hash_valid_o,
  input  logic             hash_stall_i,
  output logic [31:0]      hash_value_o
);

  logic       string_mode_q;
  logic       push, q_full, q_valid, q_pop;
  item_t      push_item, q_item;
  bk_status_t bk_status;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == AddrStringMode) ? {31'd0, string_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      string_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == AddrStringMode)) begin
      string_mode_q <= pwdata[0];
    end
  end

  // input side
  fdbh_front u_front (
    .item_valid_i  (item_valid_i),
    .item_stall_o  (item_stall_o),
    .data_byte_i   (data_byte_i),
    .has_byte_i    (has_byte_i),
    .last_i        (last_i),
    .string_mode_i (string_mode_q),
    .queue_full_i  (q_full),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  // beat queue
  fdbh_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_item_o  (q_item),
    .valid_o     (q_valid)
  );

  // hash engine
  fdbh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .hash_valid_o (hash_valid_o),
    .hash_stall_i (hash_stall_i),
    .hash_value_o (hash_value_o),
    .status_o     (bk_status)
  );

  // engine never pops while running the second pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.finalizing |-> !bk_status.pop)
    else $error("queue popped during second pass");

  // engine never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.pop |-> q_valid)
    else $error("pop from empty queue");

  // a result only appears at the end of the second pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hash_valid_o) |-> $past(bk_status.finalizing))
    else $error("result without second pass");

endmodule

>>> tb/sv/tb_fnv1a_double_byte_hash.sv
`timescale 1ns / 100ps

module tb_fnv1a_double_byte_hash;
  import fdbh_pkg::*;

  // one row of the directed stimulus table
  typedef struct {
    logic        mode;
    logic [7:0]  data;
    logic        has;
    logic        lst;
    bit          known;
    logic [31:0] hash;
  } beat_row_t;

  localparam logic [31:0] EmptyHash = 32'ha4362720;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned BeatsPerPhase = 112;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             item_valid_i = 1'b0;
  logic             item_stall_o;
  logic [7:0]       data_byte_i = '0;
  logic             has_byte_i = 1'b0;
  logic             last_i = 1'b0;
  logic             hash_valid_o;
  logic             hash_stall_i = 1'b0;
  logic [31:0]      hash_value_o;

  // predictor state and scoreboard
  logic [31:0] running_value = FnvBasis;
  logic        string_mode_model = 1'b0;
  logic [31:0] expected_hashes[$];
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned hashes_checked = 0;
  int unsigned mode_writes = 0;
  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;

  // directed beats: reset state, extremes, empty messages, string mode, mode switches
  beat_row_t directed_rows[17] = '{
    '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, EmptyHash},
    '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b0, 8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b0, 8'ha5, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b0, 8'h5a, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b0, 8'hff, 1'b0, 1'b1, 1'b1, EmptyHash},
    '{1'b0, 8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b1, 8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b1, 8'h80, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b1, 8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
    '{1'b0, 8'h7f, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b1, 8'h00, 1'b0, 1'b1, 1'b1, EmptyHash},
    '{1'b1, 8'hff, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b1, 8'h55, 1'b0, 1'b0, 1'b0, 32'h0},
    '{1'b1, 8'haa, 1'b1, 1'b1, 1'b0, 32'h0},
    '{1'b0, 8'h01, 1'b1, 1'b1, 1'b0, 32'h0}
  };

  fnv1a_double_byte_hash dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid_i (item_valid_i),
    .item_stall_o (item_stall_o),
    .data_byte_i  (data_byte_i),
    .has_byte_i   (has_byte_i),
    .last_i       (last_i),
    .hash_valid_o (hash_valid_o),
    .hash_stall_i (hash_stall_i),
    .hash_value_o (hash_value_o)
  );

  always #5 clk_i = ~clk_i;

  // one fnv-1a round: xor in the operand, multiply by the prime mod 2^32
  function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [15:0] operand);
    logic [31:0] x;
    x = h ^ {16'd0, operand};
    return x * FnvPrime;
  endfunction

  // second pass: plain fnv-1a over the four bytes, low byte first
  function automatic logic [31:0] rehash_word(logic [31:0] first);
    logic [31:0] h;
    h = FnvBasis;
    for (int n = 0; n < 4; n++) begin
      h = fnv_fold(h, {8'd0, first[8*n +: 8]});
    end
    return h;
  endfunction

  // mostly short gaps, a few long ones, none while idling is off
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // present one input beat, wait for it to be taken, then update the prediction
  task automatic send_beat(input logic [7:0] d, input logic hb, input logic lst,
                           input bit known, input logic [31:0] lit);
    int unsigned gap;
    bit          took;
    logic [15:0] operand;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid_i <= 1'b0;
      data_byte_i  <= 8'($urandom_range(0, 255));
      has_byte_i   <= 1'($urandom_range(0, 1));
      last_i       <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    item_valid_i <= 1'b1;
    data_byte_i  <= d;
    has_byte_i   <= hb;
    last_i       <= lst;
    do begin
      @(negedge clk_i);
      took = !item_stall_o;
      @(posedge clk_i);
    end while (!took);
    beats_sent++;
    if (hb) begin
      operand = string_mode_model ? 16'(d) * 16'(StringMul) : 16'(d);
      running_value = fnv_fold(running_value, operand);
    end
    if (lst) begin
      expected_hashes.push_back(known ? lit : rehash_word(running_value));
      running_value = FnvBasis;
    end
  endtask

  // let every pending hash drain and the back engine go quiet
  task automatic wait_idle();
    item_valid_i <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write string_mode over the register port, then read it back
  task automatic write_mode(input logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrStringMode;
    pwdata  <= {31'($urandom()), mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    string_mode_model = mode;
    mode_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    if (prdata[0] !== mode) begin
      $error("string_mode readback mismatch: expected %0b, got %0b", mode, prdata[0]);
      errors++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side stall: quiet stretches, short bursts, the odd long one
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!idle_on || $urandom_range(0, 99) < 60) begin
      hash_stall_i <= 1'b0;
      stall_left   <= $urandom_range(0, 4);
    end else begin
      hash_stall_i <= 1'b1;
      stall_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                  : $urandom_range(0, 2);
    end
  end

  // check each result beat against the oldest expected hash
  always @(negedge clk_i) begin
    if (rst_ni && hash_valid_o === 1'b1 && hash_stall_i === 1'b0) begin
      if (expected_hashes.size() == 0) begin
        $error("hash_value with no expected result: got %h", hash_value_o);
        errors++;
      end else begin
        if (hash_value_o !== expected_hashes[0]) begin
          $error("hash_value mismatch: expected %h, got %h",
                 expected_hashes[0], hash_value_o);
          errors++;
        end
        void'(expected_hashes.pop_front());
        hashes_checked++;
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $error("run timed out with %0d hashes outstanding", expected_hashes.size());
    $display("Simulation FAILED");
    $finish;
  end

  // main sequence
  initial begin
    int unsigned bytes_left;
    bit          msg_open;
    int unsigned sent;
    int unsigned r;
    bytes_left = 0;
    msg_open   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < $size(directed_rows); i++) begin
      if (directed_rows[i].mode != string_mode_model) begin
        wait_idle();
        write_mode(directed_rows[i].mode);
      end
      send_beat(directed_rows[i].data, directed_rows[i].has, directed_rows[i].lst,
                directed_rows[i].known, directed_rows[i].hash);
    end

    // random messages; a phase may end mid-message so the mode flips inside one
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      if (phase < 2) begin
        write_mode(phase == 0);
      end else begin
        write_mode(1'($urandom_range(0, 1)));
      end
      idle_on = (phase != 2);
      sent = 0;
      while (sent < BeatsPerPhase) begin
        if (!msg_open) begin
          r = $urandom_range(0, 99);
          if (r < 70) begin
            bytes_left = $urandom_range(0, 6);
          end else if (r < 95) begin
            bytes_left = $urandom_range(7, 24);
          end else begin
            bytes_left = $urandom_range(25, 64);
          end
          msg_open = 1'b1;
        end
        if (bytes_left > 0 && $urandom_range(0, 9) == 0) begin
          // beat with no byte: the block must ignore its data
          send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 32'h0);
          sent++;
        end else if (bytes_left > 0) begin
          send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, 32'h0);
          bytes_left--;
          sent++;
        end else begin
          send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                    1'b0, 32'h0);
          msg_open = 1'b0;
          sent++;
        end
      end
    end

    // close any open message, then drain
    if (msg_open) begin
      send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, 32'h0);
    end
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d input beats sent, %0d hashes checked", beats_sent, hashes_checked);
    $display("%0d string_mode writes, both modes and mid-message switches", mode_writes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
